### design/image_convolution_3x3_5x5_assert.svh
// Assertion macros for the convolution block
`ifndef IMAGE_CONVOLUTION_3X3_5X5_ASSERT_SVH
`define IMAGE_CONVOLUTION_3X3_5X5_ASSERT_SVH
// implication checked on every rising clock edge, quiet during reset
`define IC_ASSERT_IMPL(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication, quiet during reset
`define IC_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

### design/icv_pkg.sv
// ----------------------------------------------------------------------------
// icv_pkg
// Shared types, constants and helpers for the convolution block.
// ----------------------------------------------------------------------------
package icv_pkg;
   localparam int MaxWidth  = 1024;
   localparam int MaxHeight = 1024;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int SumW      = 24;
   localparam int DivW      = 13;
   localparam int CfgW      = 64;
   localparam int IdxW      = 3;

   typedef enum logic [IdxW-1:0] {
      REG_MODE   = 3'd0,
      REG_WIDTH  = 3'd1,
      REG_HEIGHT = 3'd2,
      REG_COEF0  = 3'd3,
      REG_COEF1  = 3'd4,
      REG_COEF2  = 3'd5,
      REG_COEF3  = 3'd6,
      REG_DIV    = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic load;       // latch pixel, read line store
      logic mac_start;  // start sum of products
      logic div_start;  // start divide
      logic emit;       // result to output register
   } cmd_type;

   typedef struct packed {
      logic mac_done;
      logic div_done;
      logic produce;    // current pixel yields a result
   } sts_type;

   function automatic logic [10:0] clamp_size(input logic [10:0] v, input logic [10:0] hi);
      logic [10:0] r;
      begin
         r = v;
         if (v < 11'd5) r = 11'd5;
         else if (v > hi) r = hi;
         return r;
      end
   endfunction
endpackage

### design/icv_ram.sv
// ----------------------------------------------------------------------------
// icv_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module icv_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      rdata <= mem_ff[addr];
   end
endmodule

### design/icv_ctrl.sv
// ----------------------------------------------------------------------------
// icv_ctrl
// Sequencer: accept request, read line store, sum products, divide, emit.
// ----------------------------------------------------------------------------
module icv_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output icv_pkg::cmd_type cmd,
   input  icv_pkg::sts_type sts
);
   import icv_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_MAC, S_DIV, S_OUT} state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (sts.produce) begin
               cmd.mac_start = 1'b1;
               state_in = S_MAC;
            end else state_in = S_IDLE;
         end
         S_MAC: begin
            if (sts.mac_done) begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### design/icv_dp.sv
// ----------------------------------------------------------------------------
// icv_dp
// Datapath: position counters, line store, window, MAC and serial divider.
// ----------------------------------------------------------------------------
module icv_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [icv_pkg::IdxW-1:0]     csr_index,
   input  logic [icv_pkg::CfgW-1:0]     csr_data,
   input  logic [7:0]                   req_pixel,
   output logic [7:0]                   rsp_value,
   output logic [9:0]                   rsp_out_row,
   output logic [9:0]                   rsp_out_col,
   output logic                         rsp_last_of_frame,
   input  icv_pkg::cmd_type             cmd,
   output icv_pkg::sts_type             sts
);
   import icv_pkg::*;

   logic             mode_ff;
   logic [10:0]      width_ff, height_ff;
   logic [7:0]       coef_ff [25];
   logic signed [DivW-1:0] div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         width_ff  <= 11'd512;
         height_ff <= 11'd512;
         div_ff    <= '0;
         for (int k = 0; k < 25; k++) coef_ff[k] <= '0;
      end else if (csr_write) begin
         case (reg_idx_type'(csr_index))
            REG_MODE:   mode_ff   <= csr_data[0];
            REG_WIDTH:  width_ff  <= csr_data[10:0];
            REG_HEIGHT: height_ff <= csr_data[10:0];
            REG_COEF0:  for (int k = 0; k < 8; k++) coef_ff[k]    <= csr_data[k*8 +: 8];
            REG_COEF1:  for (int k = 0; k < 8; k++) coef_ff[8+k]  <= csr_data[k*8 +: 8];
            REG_COEF2:  for (int k = 0; k < 8; k++) coef_ff[16+k] <= csr_data[k*8 +: 8];
            REG_COEF3:  coef_ff[24] <= csr_data[7:0];
            REG_DIV:    div_ff    <= csr_data[DivW-1:0];
            default: ;
         endcase
      end
   end

   logic [10:0] w_eff, h_eff;
   assign w_eff = clamp_size(width_ff, 11'(MaxWidth));
   assign h_eff = clamp_size(height_ff, 11'(MaxHeight));

   // position counters
   logic [10:0] col_ff, row_ff, col_in, row_in;
   logic [10:0] cur_col_ff, cur_row_ff;
   logic [7:0]  pix_ff;
   always_comb begin
      col_in = col_ff + 11'd1;
      row_in = row_ff;
      if (col_in >= w_eff) begin
         col_in = '0;
         row_in = row_ff + 11'd1;
      end
      if (row_in >= h_eff) row_in = '0;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
      if (cmd.load) begin
         cur_col_ff <= col_ff;
         cur_row_ff <= row_ff;
         pix_ff     <= req_pixel;
      end
   end

   // line store: read on load, write back in the read cycle
   logic [31:0] ls_rdata;
   logic        ls_we;
   logic [ColW-1:0] ls_addr;
   logic        reading_ff;
   always_ff @(posedge clock) begin
      if (reset) reading_ff <= 1'b0;
      else reading_ff <= cmd.load;
   end
   assign ls_we   = reading_ff;
   assign ls_addr = reading_ff ? cur_col_ff[ColW-1:0] : col_ff[ColW-1:0];
   icv_ram #(.Width(32), .Depth(MaxWidth)) u_line (
      .clock(clock), .we(ls_we), .addr(ls_addr),
      .wdata({ls_rdata[23:0], pix_ff}), .rdata(ls_rdata)
   );

   // window shift on read cycle; row 4 is newest
   logic [7:0] win_ff [5][5];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++) win_ff[i][j] <= '0;
      end else if (reading_ff) begin
         for (int i = 0; i < 5; i++)
            for (int j = 0; j < 4; j++) win_ff[i][j] <= win_ff[i][j+1];
         for (int i = 0; i < 4; i++) win_ff[i][4] <= ls_rdata[(3-i)*8 +: 8];
         win_ff[4][4] <= pix_ff;
      end
   end

   logic [2:0] ks;
   assign ks = mode_ff ? 3'd5 : 3'd3;
   assign sts.produce = (cur_col_ff < w_eff) && (cur_row_ff < h_eff)
                     && (cur_col_ff >= 11'(ks - 3'd1)) && (cur_row_ff >= 11'(ks - 3'd1));

   // serial MAC: one tap per cycle
   logic [4:0] tap_ff;
   logic [2:0] ti_ff, tj_ff;
   logic       mac_busy_ff;
   logic signed [SumW-1:0] sum_ff;
   logic [2:0] off;
   logic [7:0] p_sel;
   logic signed [16:0] prod;
   assign off   = mode_ff ? 3'd0 : 3'd2;
   assign p_sel = win_ff[ti_ff + off][tj_ff + off];
   assign prod  = $signed({1'b0, p_sel}) * $signed(coef_ff[tap_ff]);
   always_ff @(posedge clock) begin
      if (reset) mac_busy_ff <= 1'b0;
      else if (cmd.mac_start) mac_busy_ff <= 1'b1;
      else if (mac_busy_ff && tap_ff == 5'(ks * ks - 1)) mac_busy_ff <= 1'b0;
      if (cmd.mac_start) begin
         tap_ff <= '0; ti_ff <= '0; tj_ff <= '0; sum_ff <= '0;
      end else if (mac_busy_ff) begin
         sum_ff <= sum_ff + SumW'(prod);
         tap_ff <= tap_ff + 5'd1;
         if (tj_ff == ks - 3'd1) begin
            tj_ff <= '0; ti_ff <= ti_ff + 3'd1;
         end else tj_ff <= tj_ff + 3'd1;
      end
   end
   assign sts.mac_done = mac_busy_ff && tap_ff == 5'(ks * ks - 1);

   // restoring divider on magnitudes, one quotient bit per cycle
   logic [SumW-1:0] num_mag, rem_ff, quo_ff;
   logic [DivW-1:0] den_mag;
   logic [4:0]      dcnt_ff;
   logic            div_busy_ff, neg_ff, nodiv_ff;
   logic [SumW:0]   trial;
   logic signed [SumW-1:0] fin_sum;
   assign fin_sum = sum_ff + SumW'(prod);
   assign num_mag = fin_sum[SumW-1] ? SumW'(-fin_sum) : fin_sum;
   assign den_mag = div_ff[DivW-1] ? DivW'(-div_ff) : div_ff;
   assign trial   = {rem_ff, quo_ff[SumW-1]} - {12'd0, den_mag};
   always_ff @(posedge clock) begin
      if (reset) div_busy_ff <= 1'b0;
      else if (cmd.div_start) div_busy_ff <= (div_ff != '0);
      else if (div_busy_ff && dcnt_ff == 5'(SumW - 1)) div_busy_ff <= 1'b0;
      if (cmd.div_start) begin
         rem_ff   <= '0;
         quo_ff   <= (div_ff == '0) ? fin_sum : num_mag;
         neg_ff   <= fin_sum[SumW-1] ^ div_ff[DivW-1];
         nodiv_ff <= (div_ff == '0);
         dcnt_ff  <= '0;
      end else if (div_busy_ff) begin
         dcnt_ff <= dcnt_ff + 5'd1;
         if (!trial[SumW]) begin
            rem_ff <= trial[SumW-1:0];
            quo_ff <= {quo_ff[SumW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[SumW-2:0], quo_ff[SumW-1]};
            quo_ff <= {quo_ff[SumW-2:0], 1'b0};
         end
      end
   end
   logic div_started_ff;
   always_ff @(posedge clock) begin
      if (reset) div_started_ff <= 1'b0;
      else div_started_ff <= cmd.div_start;
   end
   assign sts.div_done = (div_started_ff && nodiv_ff) || (div_busy_ff && dcnt_ff == 5'(SumW - 1));

   logic [7:0] res;
   logic [2:0] half;
   assign res  = (nodiv_ff || !neg_ff) ? quo_ff[7:0] : 8'(-quo_ff[7:0]);
   assign half = mode_ff ? 3'd2 : 3'd1;
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value         <= res;
         rsp_out_row       <= 10'(cur_row_ff - 11'(half));
         rsp_out_col       <= 10'(cur_col_ff - 11'(half));
         rsp_last_of_frame <= (cur_row_ff == h_eff - 11'd1) && (cur_col_ff == w_eff - 11'd1);
      end
   end
endmodule

### design/image_convolution_3x3_5x5.sv
// ----------------------------------------------------------------------------
// image_convolution_3x3_5x5
// Streamed 3x3/5x5 signed convolution with optional signed divide.
// ----------------------------------------------------------------------------
// A border pixel gives no result. One request is taken at a time: the next
// waits until the current pixel is done, including any result stall. A serial
// MAC (one tap per cycle) and a 24-step restoring divider set the pace; the
// divider is skipped when the divisor is 0.
// Reset: synchronous, clears position counters, window, control state and configuration registers to defaults.
module image_convolution_3x3_5x5 (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_value,
   output logic [9:0]               rsp_out_row,
   output logic [9:0]               rsp_out_col,
   output logic                     rsp_last_of_frame,
   input  logic                     csr_write,
   input  logic [icv_pkg::IdxW-1:0] csr_index,
   input  logic [icv_pkg::CfgW-1:0] csr_data
);
   import icv_pkg::*;
   `include "image_convolution_3x3_5x5_assert.svh"

   cmd_type    cmd;
   sts_type    sts;
   logic [3:0] cmd_bits;

   assign cmd_bits = cmd;

   icv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .sts(sts)
   );

   icv_dp u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .req_pixel(req_pixel), .rsp_value(rsp_value),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col),
      .rsp_last_of_frame(rsp_last_of_frame), .cmd(cmd), .sts(sts)
   );

   `IC_ASSERT_IMPL(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd_bits), "multiple commands")
   `IC_ASSERT_NEXT(a_load_stalls, clock, reset, cmd.load, req_stall, "no stall after load")
   `IC_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit, rsp_valid, "emit without valid")
endmodule
